// ----- rtl/skrt_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted key record table package
// Shared types, command and status codes, and cell control for the table.
// ----------------------------------------------------------------------------
package skrt_pkg;

  localparam int DEFAULT_CAPACITY = 64;

  localparam int ACTION_W = 2;
  localparam int KEY_W    = 32;
  localparam int NAME_W   = 64;
  localparam int STATUS_W = 4;

  // Command codes.
  localparam logic [ACTION_W-1:0] ACT_ADD    = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_DELETE = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_SHOW   = 2'd2;
  localparam logic [ACTION_W-1:0] ACT_LIST   = 2'd3;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_ADDED    = 4'd0;
  localparam logic [STATUS_W-1:0] ST_EXISTS   = 4'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_NAME = 4'd2;
  localparam logic [STATUS_W-1:0] ST_DELETED  = 4'd3;
  localparam logic [STATUS_W-1:0] ST_ABSENT   = 4'd4;
  localparam logic [STATUS_W-1:0] ST_FOUND    = 4'd5;
  localparam logic [STATUS_W-1:0] ST_LISTED   = 4'd6;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 4'd7;
  localparam logic [STATUS_W-1:0] ST_FULL     = 4'd8;

  // Cell operations.
  localparam int CELL_OP_W = 3;
  localparam logic [CELL_OP_W-1:0] CELL_HOLD   = 3'd0;
  localparam logic [CELL_OP_W-1:0] CELL_SEARCH = 3'd1;
  localparam logic [CELL_OP_W-1:0] CELL_INSERT = 3'd2;
  localparam logic [CELL_OP_W-1:0] CELL_DELETE = 3'd3;
  localparam logic [CELL_OP_W-1:0] CELL_ROTATE = 3'd4;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [KEY_W-1:0]    record_key;
    logic [NAME_W-1:0]   first_name;
    logic [NAME_W-1:0]   last_name;
  } in_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [KEY_W-1:0]    out_key;
    logic [NAME_W-1:0]   out_first;
    logic [NAME_W-1:0]   out_last;
    logic                last_of_run;
  } out_t;

  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [NAME_W-1:0] first;
    logic [NAME_W-1:0] last;
  } rec_t;

  typedef struct packed {
    logic [CELL_OP_W-1:0] op;
    rec_t                 rec;
  } cell_ctrl_t;

endpackage

// ----- rtl/sorted_key_record_table.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted key record table
// Records kept in ascending key order in a chain of cells.
// ----------------------------------------------------------------------------
// Usage: a command transaction on the in_ channel carries an action, a key and
// two packed names. The block takes one command at a time; in_stall stays high
// from the accepting edge until the command has finished, including any
// rotation that goes on after its result has reached the output register.
// Results leave on the out_ channel, one transaction each, with last_of_run
// marking the final result of a command.
// Sequence: after acceptance, the search state broadcasts the key so every cell
// compares it with its record, and the exec state then decides and, for add
// and delete, shifts the whole chain at once when the output register is free.
// Add, delete, an absent show and a list of an empty table finish there. A
// show that hits and a non-empty list-all rotate the occupied cells once
// around, one step per cycle while the output register is free, for entry_count
// steps; list-all emits one result per step. The rotation restores the order.
// Stalls: the output register is refilled only when it is empty or being
// taken, so a stalled receiver freezes the chain and no result is lost.
// Reset: clears the entry count and the control state; cell contents are left
// as they are and read only below the entry count.
// ----------------------------------------------------------------------------
module sorted_key_record_table #(
  parameter int CAPACITY = skrt_pkg::DEFAULT_CAPACITY
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  skrt_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output skrt_pkg::out_t out_data
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SEARCH = 2'd1;
  localparam logic [1:0] S_EXEC   = 2'd2;
  localparam logic [1:0] S_ROTATE = 2'd3;

  logic [1:0]       state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] step_r, step_nxt;
  skrt_pkg::in_t    cmd_r;
  logic             out_valid_r;
  skrt_pkg::out_t   out_data_r;

  skrt_pkg::cell_ctrl_t ctrl;
  skrt_pkg::rec_t       cell_rec [CAPACITY];
  logic [CAPACITY-1:0]  lt_vec;
  logic [CAPACITY-1:0]  eq_vec;

  logic           out_free;
  logic           emit;
  skrt_pkg::out_t emit_data;
  logic           found;
  logic           last_step;
  skrt_pkg::rec_t head;

  assign out_free  = !out_valid_r || !out_stall;
  assign found     = |eq_vec;
  assign head      = cell_rec[0];
  assign last_step = (CNT_W'(step_r + 1'b1) == count_r);
  assign in_stall  = (state_r != S_IDLE);

  // Command sequencer. The new record travels with the control word to every
  // cell.
  always_comb begin
    state_nxt             = state_r;
    count_nxt             = count_r;
    step_nxt              = step_r;
    ctrl.op               = skrt_pkg::CELL_HOLD;
    ctrl.rec.key          = cmd_r.record_key;
    ctrl.rec.first        = cmd_r.first_name;
    ctrl.rec.last         = cmd_r.last_name;
    emit                  = 1'b0;
    emit_data.status      = skrt_pkg::ST_ADDED;
    emit_data.out_key     = cmd_r.record_key;
    emit_data.out_first   = '0;
    emit_data.out_last    = '0;
    emit_data.last_of_run = 1'b1;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_SEARCH;
        end
      end
      S_SEARCH: begin
        ctrl.op   = skrt_pkg::CELL_SEARCH;
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        step_nxt = '0;
        case (cmd_r.action)
          skrt_pkg::ACT_ADD: begin
            if (found) begin
              emit_data.status = skrt_pkg::ST_EXISTS;
            end else if (cmd_r.first_name == '0 || cmd_r.last_name == '0) begin
              emit_data.status = skrt_pkg::ST_BAD_NAME;
            end else if (count_r == CNT_W'(CAPACITY)) begin
              emit_data.status = skrt_pkg::ST_FULL;
            end else begin
              emit_data.status = skrt_pkg::ST_ADDED;
            end
            if (out_free) begin
              emit      = 1'b1;
              state_nxt = S_IDLE;
              if (emit_data.status == skrt_pkg::ST_ADDED) begin
                ctrl.op   = skrt_pkg::CELL_INSERT;
                count_nxt = CNT_W'(count_r + 1'b1);
              end
            end
          end
          skrt_pkg::ACT_DELETE: begin
            emit_data.status = found ? skrt_pkg::ST_DELETED : skrt_pkg::ST_ABSENT;
            if (out_free) begin
              emit      = 1'b1;
              state_nxt = S_IDLE;
              if (found) begin
                ctrl.op   = skrt_pkg::CELL_DELETE;
                count_nxt = CNT_W'(count_r - 1'b1);
              end
            end
          end
          skrt_pkg::ACT_SHOW: begin
            emit_data.status = skrt_pkg::ST_ABSENT;
            if (found) begin
              state_nxt = S_ROTATE;
            end else if (out_free) begin
              emit      = 1'b1;
              state_nxt = S_IDLE;
            end
          end
          default: begin
            // List-all: an empty table gives one result with the empty status, a zero key and zero names.
            emit_data.status  = skrt_pkg::ST_EMPTY;
            emit_data.out_key = '0;
            if (count_r != '0) begin
              state_nxt = S_ROTATE;
            end else if (out_free) begin
              emit      = 1'b1;
              state_nxt = S_IDLE;
            end
          end
        endcase
      end
      default: begin
        // Rotation: the head cell presents the record at original index step.
        emit_data.out_key   = head.key;
        emit_data.out_first = head.first;
        emit_data.out_last  = head.last;
        if (cmd_r.action == skrt_pkg::ACT_LIST) begin
          emit_data.status      = skrt_pkg::ST_LISTED;
          emit_data.last_of_run = last_step;
        end else begin
          emit_data.status = skrt_pkg::ST_FOUND;
        end
        if (out_free) begin
          ctrl.op  = skrt_pkg::CELL_ROTATE;
          step_nxt = CNT_W'(step_r + 1'b1);
          emit     = (cmd_r.action == skrt_pkg::ACT_LIST) ||
                     (head.key == cmd_r.record_key);
          if (last_step) begin
            state_nxt = S_IDLE;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      step_r  <= step_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_valid) begin
      cmd_r <= in_data;
    end
    if (emit) begin
      out_data_r <= emit_data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // The cell chain: each cell sees its neighbors, the head and flags derived from the count.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic           occupied;
    logic           is_tail;
    logic           left_lt;
    skrt_pkg::rec_t left_rec;
    skrt_pkg::rec_t right_rec;

    assign occupied = (CNT_W'(i) < count_r);
    assign is_tail  = (CNT_W'(i + 1) == count_r);

    if (i == 0) begin : g_first
      assign left_lt  = 1'b1;
      assign left_rec = ctrl.rec;
    end else begin : g_inner
      assign left_lt  = lt_vec[i-1];
      assign left_rec = cell_rec[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_rec = cell_rec[i];
    end else begin : g_body
      assign right_rec = cell_rec[i+1];
    end

    skrt_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctrl      (ctrl),
      .occupied  (occupied),
      .is_tail   (is_tail),
      .left_lt   (left_lt),
      .left_rec  (left_rec),
      .right_rec (right_rec),
      .head_rec  (head),
      .rec       (cell_rec[i]),
      .lt        (lt_vec[i]),
      .eq        (eq_vec[i])
    );
  end

endmodule

// ----- rtl/skrt_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted key record table cell
// Holds one record, compares it with the broadcast key and shifts or rotates.
// ----------------------------------------------------------------------------
module skrt_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  skrt_pkg::cell_ctrl_t ctrl,
  input  logic                occupied,
  input  logic                is_tail,
  input  logic                left_lt,
  input  skrt_pkg::rec_t      left_rec,
  input  skrt_pkg::rec_t      right_rec,
  input  skrt_pkg::rec_t      head_rec,
  output skrt_pkg::rec_t      rec,
  output logic                lt,
  output logic                eq
);

  skrt_pkg::rec_t rec_r, rec_nxt;
  logic           lt_r, lt_nxt;
  logic           eq_r, eq_nxt;

  always_comb begin
    rec_nxt = rec_r;
    lt_nxt  = lt_r;
    eq_nxt  = eq_r;
    case (ctrl.op)
      skrt_pkg::CELL_SEARCH: begin
        lt_nxt = occupied && (rec_r.key < ctrl.rec.key);
        eq_nxt = occupied && (rec_r.key == ctrl.rec.key);
      end
      skrt_pkg::CELL_INSERT: begin
        // Cells holding smaller keys stay; the first other cell takes the new
        // record and every cell after it takes its left neighbor.
        if (!lt_r) begin
          rec_nxt = left_lt ? ctrl.rec : left_rec;
        end
      end
      skrt_pkg::CELL_DELETE: begin
        if (!lt_r) begin
          rec_nxt = right_rec;
        end
      end
      skrt_pkg::CELL_ROTATE: begin
        if (occupied) begin
          rec_nxt = is_tail ? head_rec : right_rec;
        end
      end
      default: begin
        rec_nxt = rec_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    rec_r <= rec_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lt_r <= 1'b0;
      eq_r <= 1'b0;
    end else begin
      lt_r <= lt_nxt;
      eq_r <= eq_nxt;
    end
  end

  assign rec = rec_r;
  assign lt  = lt_r;
  assign eq  = eq_r;

endmodule
